### rtl/stpf_pkg.sv
package stpf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);
  localparam int NTMP          = 16;
  localparam int TMP_W         = $clog2(NTMP);
  localparam int PC_W          = 7;

  localparam logic signed [63:0] QMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QONE    = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] LUCY_3D = 64'sd107661530903;
  localparam logic signed [63:0] LUCY_2D = 64'sd82027833069;

  typedef struct packed {
    logic [31:0] rest_density;
    logic [31:0] tait_b;
    logic [31:0] particle_mass;
    logic [31:0] smoothing_length;
    logic [31:0] dyn_viscosity;
    logic        dimension_3d;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_REST_DENSITY,
    CFG_TAIT_B,
    CFG_PARTICLE_MASS,
    CFG_SMOOTHING_LENGTH,
    CFG_DYN_VISCOSITY,
    CFG_DIMENSION_3D
  } cfg_idx_t;

  typedef struct packed {
    logic               cut;
    logic [63:0]        rsq;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        rhoi;
    logic [31:0]        rhoj;
  } pair_t;

  typedef enum logic [2:0] {OP_ADD, OP_MUL, OP_DIV, OP_HALF, OP_SQRT, OP_END} op_t;
  typedef enum logic [2:0] {CAP_NONE, CAP_FX, CAP_FY, CAP_FZ, CAP_DRHO, CAP_DE} cap_t;
  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WB, ST_EMIT} st_t;

  // operand sources; codes with the top bit set name a temp register
  localparam logic [4:0] SRC_DX   = 5'd0;
  localparam logic [4:0] SRC_DY   = 5'd1;
  localparam logic [4:0] SRC_DZ   = 5'd2;
  localparam logic [4:0] SRC_VX   = 5'd3;
  localparam logic [4:0] SRC_VY   = 5'd4;
  localparam logic [4:0] SRC_VZ   = 5'd5;
  localparam logic [4:0] SRC_RHOI = 5'd6;
  localparam logic [4:0] SRC_RHOJ = 5'd7;
  localparam logic [4:0] SRC_H    = 5'd8;
  localparam logic [4:0] SRC_M    = 5'd9;
  localparam logic [4:0] SRC_RHO0 = 5'd10;
  localparam logic [4:0] SRC_B    = 5'd11;
  localparam logic [4:0] SRC_MU   = 5'd12;
  localparam logic [4:0] SRC_QONE = 5'd13;
  localparam logic [4:0] SRC_LUCY = 5'd14;
  localparam logic [4:0] SRC_ZERO = 5'd15;

  localparam logic [TMP_W-1:0] T0 = 4'd0;
  localparam logic [TMP_W-1:0] T1 = 4'd1;
  localparam logic [TMP_W-1:0] T2 = 4'd2;
  localparam logic [TMP_W-1:0] T3 = 4'd3;
  localparam logic [TMP_W-1:0] T4 = 4'd4;
  localparam logic [TMP_W-1:0] T5 = 4'd5;
  localparam logic [TMP_W-1:0] T6 = 4'd6;
  localparam logic [TMP_W-1:0] T7 = 4'd7;
  localparam logic [TMP_W-1:0] T8 = 4'd8;
  localparam logic [TMP_W-1:0] T9 = 4'd9;

  typedef struct packed {
    op_t              op;
    logic [TMP_W-1:0] dst;
    logic [4:0]       sa;
    logic [4:0]       sb;
    logic             negb;
    logic             only3d;
    cap_t             cap;
  } uop_t;

  function automatic logic [4:0] ts(input logic [TMP_W-1:0] i);
    return {1'b1, i};
  endfunction

  function automatic uop_t uop(input op_t op, input logic [TMP_W-1:0] dst,
                               input logic [4:0] sa, input logic [4:0] sb,
                               input logic negb, input logic only3d, input cap_t cap);
    uop_t u;
    u.op = op; u.dst = dst; u.sa = sa; u.sb = sb;
    u.negb = negb; u.only3d = only3d; u.cap = cap;
    return u;
  endfunction

  function automatic uop_t uc_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // pressure term of i
      7'd0:  u = uop(OP_DIV, T0, SRC_RHOI, SRC_RHO0, 1'b0, 1'b0, CAP_NONE);
      7'd1:  u = uop(OP_MUL, T1, ts(T0), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd2:  u = uop(OP_MUL, T1, ts(T1), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd3:  u = uop(OP_MUL, T1, ts(T1), ts(T1), 1'b0, 1'b0, CAP_NONE);
      7'd4:  u = uop(OP_MUL, T1, ts(T1), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd5:  u = uop(OP_ADD, T1, ts(T1), SRC_QONE, 1'b1, 1'b0, CAP_NONE);
      7'd6:  u = uop(OP_MUL, T1, SRC_B, ts(T1), 1'b0, 1'b0, CAP_NONE);
      7'd7:  u = uop(OP_DIV, T1, ts(T1), SRC_RHOI, 1'b0, 1'b0, CAP_NONE);
      7'd8:  u = uop(OP_DIV, T1, ts(T1), SRC_RHOI, 1'b0, 1'b0, CAP_NONE);
      // pressure term of j
      7'd9:  u = uop(OP_DIV, T0, SRC_RHOJ, SRC_RHO0, 1'b0, 1'b0, CAP_NONE);
      7'd10: u = uop(OP_MUL, T2, ts(T0), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd11: u = uop(OP_MUL, T2, ts(T2), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd12: u = uop(OP_MUL, T2, ts(T2), ts(T2), 1'b0, 1'b0, CAP_NONE);
      7'd13: u = uop(OP_MUL, T2, ts(T2), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd14: u = uop(OP_ADD, T2, ts(T2), SRC_QONE, 1'b1, 1'b0, CAP_NONE);
      7'd15: u = uop(OP_MUL, T2, SRC_B, ts(T2), 1'b0, 1'b0, CAP_NONE);
      7'd16: u = uop(OP_DIV, T2, ts(T2), SRC_RHOJ, 1'b0, 1'b0, CAP_NONE);
      7'd17: u = uop(OP_DIV, T2, ts(T2), SRC_RHOJ, 1'b0, 1'b0, CAP_NONE);
      7'd18: u = uop(OP_ADD, T1, ts(T1), ts(T2), 1'b0, 1'b0, CAP_NONE);
      // kernel derivative
      7'd19: u = uop(OP_SQRT, T0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, CAP_NONE);
      7'd20: u = uop(OP_ADD, T0, SRC_H, ts(T0), 1'b1, 1'b0, CAP_NONE);
      7'd21: u = uop(OP_DIV, T0, ts(T0), SRC_H, 1'b0, 1'b0, CAP_NONE);
      7'd22: u = uop(OP_MUL, T0, ts(T0), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd23: u = uop(OP_MUL, T0, SRC_LUCY, ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd24: u = uop(OP_DIV, T0, ts(T0), SRC_H, 1'b0, 1'b0, CAP_NONE);
      7'd25: u = uop(OP_DIV, T0, ts(T0), SRC_H, 1'b0, 1'b0, CAP_NONE);
      7'd26: u = uop(OP_DIV, T0, ts(T0), SRC_H, 1'b0, 1'b0, CAP_NONE);
      7'd27: u = uop(OP_DIV, T0, ts(T0), SRC_H, 1'b0, 1'b0, CAP_NONE);
      7'd28: u = uop(OP_DIV, T0, ts(T0), SRC_H, 1'b0, 1'b1, CAP_NONE);
      7'd29: u = uop(OP_ADD, T0, SRC_ZERO, ts(T0), 1'b1, 1'b0, CAP_NONE);
      // dvr and vsq
      7'd30: u = uop(OP_MUL, T2, SRC_DX, SRC_VX, 1'b0, 1'b0, CAP_NONE);
      7'd31: u = uop(OP_MUL, T3, SRC_DY, SRC_VY, 1'b0, 1'b0, CAP_NONE);
      7'd32: u = uop(OP_ADD, T2, ts(T2), ts(T3), 1'b0, 1'b0, CAP_NONE);
      7'd33: u = uop(OP_MUL, T3, SRC_DZ, SRC_VZ, 1'b0, 1'b0, CAP_NONE);
      7'd34: u = uop(OP_ADD, T2, ts(T2), ts(T3), 1'b0, 1'b0, CAP_NONE);
      7'd35: u = uop(OP_MUL, T3, SRC_VX, SRC_VX, 1'b0, 1'b0, CAP_NONE);
      7'd36: u = uop(OP_MUL, T4, SRC_VY, SRC_VY, 1'b0, 1'b0, CAP_NONE);
      7'd37: u = uop(OP_ADD, T3, ts(T3), ts(T4), 1'b0, 1'b0, CAP_NONE);
      7'd38: u = uop(OP_MUL, T4, SRC_VZ, SRC_VZ, 1'b0, 1'b0, CAP_NONE);
      7'd39: u = uop(OP_ADD, T3, ts(T3), ts(T4), 1'b0, 1'b0, CAP_NONE);
      // viscous term
      7'd40: u = uop(OP_ADD, T4, SRC_MU, SRC_MU, 1'b0, 1'b0, CAP_NONE);
      7'd41: u = uop(OP_DIV, T4, ts(T4), SRC_RHOI, 1'b0, 1'b0, CAP_NONE);
      7'd42: u = uop(OP_DIV, T4, ts(T4), SRC_RHOJ, 1'b0, 1'b0, CAP_NONE);
      7'd43: u = uop(OP_MUL, T4, ts(T4), SRC_M, 1'b0, 1'b0, CAP_NONE);
      7'd44: u = uop(OP_MUL, T4, ts(T4), SRC_M, 1'b0, 1'b0, CAP_NONE);
      7'd45: u = uop(OP_MUL, T4, ts(T4), ts(T0), 1'b0, 1'b0, CAP_NONE);
      // pair force
      7'd46: u = uop(OP_MUL, T5, SRC_M, SRC_M, 1'b0, 1'b0, CAP_NONE);
      7'd47: u = uop(OP_MUL, T5, ts(T5), ts(T1), 1'b0, 1'b0, CAP_NONE);
      7'd48: u = uop(OP_MUL, T5, ts(T5), ts(T0), 1'b0, 1'b0, CAP_NONE);
      7'd49: u = uop(OP_ADD, T5, SRC_ZERO, ts(T5), 1'b1, 1'b0, CAP_NONE);
      // energy and density
      7'd50: u = uop(OP_MUL, T6, ts(T5), ts(T2), 1'b0, 1'b0, CAP_NONE);
      7'd51: u = uop(OP_MUL, T7, ts(T4), ts(T3), 1'b0, 1'b0, CAP_NONE);
      7'd52: u = uop(OP_ADD, T6, ts(T6), ts(T7), 1'b0, 1'b0, CAP_NONE);
      7'd53: u = uop(OP_HALF, T6, ts(T6), SRC_ZERO, 1'b0, 1'b0, CAP_DE);
      7'd54: u = uop(OP_MUL, T7, SRC_M, ts(T2), 1'b0, 1'b0, CAP_NONE);
      7'd55: u = uop(OP_MUL, T7, ts(T7), ts(T0), 1'b0, 1'b0, CAP_DRHO);
      // force
      7'd56: u = uop(OP_MUL, T8, SRC_DX, ts(T5), 1'b0, 1'b0, CAP_NONE);
      7'd57: u = uop(OP_MUL, T9, SRC_VX, ts(T4), 1'b0, 1'b0, CAP_NONE);
      7'd58: u = uop(OP_ADD, T8, ts(T8), ts(T9), 1'b0, 1'b0, CAP_FX);
      7'd59: u = uop(OP_MUL, T8, SRC_DY, ts(T5), 1'b0, 1'b0, CAP_NONE);
      7'd60: u = uop(OP_MUL, T9, SRC_VY, ts(T4), 1'b0, 1'b0, CAP_NONE);
      7'd61: u = uop(OP_ADD, T8, ts(T8), ts(T9), 1'b0, 1'b0, CAP_FY);
      7'd62: u = uop(OP_MUL, T8, SRC_DZ, ts(T5), 1'b0, 1'b0, CAP_NONE);
      7'd63: u = uop(OP_MUL, T9, SRC_VZ, ts(T4), 1'b0, 1'b0, CAP_NONE);
      7'd64: u = uop(OP_ADD, T8, ts(T8), ts(T9), 1'b0, 1'b0, CAP_FZ);
      default: u = uop(OP_END, T0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, CAP_NONE);
    endcase
    return u;
  endfunction

endpackage

### rtl/sph_tait_morris_pair_force_unit.sv
// SPH pair force unit (Tait pressure, Lucy kernel, Morris viscosity). A pair is
// taken when start is high and busy is low; its result appears on the out_
// ports for one cycle with out_valid and cannot be held off. The front end
// registers the squares of the separation, then sums them and tests the cutoff
// as it parks the item in a four-deep queue; busy is raised while the queue
// and the stage ahead of it together hold four items.
// The back end runs each in-cutoff pair through a 65-step sequence on one
// shared 64x64 multiplier (four 32x32 partial products), one bit-serial
// divider (14 quotients in 3-D, 13 in 2-D; it does not iterate when the quotient
// saturates or the divisor is zero) and a bit-serial square root. A pair outside
// the cutoff skips the sequence and goes straight to an all-zero result.
module sph_tait_morris_pair_force_unit #(
  parameter int FRAC_BITS = stpf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_del_x,
  input  logic signed [31:0] in_del_y,
  input  logic signed [31:0] in_del_z,
  input  logic signed [31:0] in_dvel_x,
  input  logic signed [31:0] in_dvel_y,
  input  logic signed [31:0] in_dvel_z,
  input  logic [31:0]        in_density_i,
  input  logic [31:0]        in_density_j,
  output logic               out_valid,
  output logic signed [63:0] out_force_x,
  output logic signed [63:0] out_force_y,
  output logic signed [63:0] out_force_z,
  output logic signed [63:0] out_density_rate,
  output logic signed [63:0] out_energy_rate,
  output logic               out_in_cutoff,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  stpf_pkg::cfg_t                 cfg_r;
  logic                           push, pop, q_empty;
  stpf_pkg::pair_t                push_item, q_head;
  logic [stpf_pkg::QCNT_W-1:0]    q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_density     <= 32'h0001_0000;
      cfg_r.tait_b           <= 32'h0001_0000;
      cfg_r.particle_mass    <= 32'h0001_0000;
      cfg_r.smoothing_length <= 32'h0001_0000;
      cfg_r.dyn_viscosity    <= 32'h0000_0000;
      cfg_r.dimension_3d     <= 1'b1;
    end else if (cfg_we) begin
      case (stpf_pkg::cfg_idx_t'(cfg_index))
        stpf_pkg::CFG_REST_DENSITY:     cfg_r.rest_density     <= cfg_wdata;
        stpf_pkg::CFG_TAIT_B:           cfg_r.tait_b           <= cfg_wdata;
        stpf_pkg::CFG_PARTICLE_MASS:    cfg_r.particle_mass    <= cfg_wdata;
        stpf_pkg::CFG_SMOOTHING_LENGTH: cfg_r.smoothing_length <= cfg_wdata;
        stpf_pkg::CFG_DYN_VISCOSITY:    cfg_r.dyn_viscosity    <= cfg_wdata;
        stpf_pkg::CFG_DIMENSION_3D:     cfg_r.dimension_3d     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  stpf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_del_x         (in_del_x),
    .in_del_y         (in_del_y),
    .in_del_z         (in_del_z),
    .in_dvel_x        (in_dvel_x),
    .in_dvel_y        (in_dvel_y),
    .in_dvel_z        (in_dvel_z),
    .in_density_i     (in_density_i),
    .in_density_j     (in_density_j),
    .smoothing_length (cfg_r.smoothing_length),
    .q_count          (q_count),
    .push             (push),
    .push_item        (push_item)
  );

  stpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  stpf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y),
    .out_force_z      (out_force_z),
    .out_density_rate (out_density_rate),
    .out_energy_rate  (out_energy_rate),
    .out_in_cutoff    (out_in_cutoff)
  );

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= stpf_pkg::QCNT_W'(stpf_pkg::QDEPTH) && !(push && q_count ==
    stpf_pkg::QCNT_W'(stpf_pkg::QDEPTH) && !pop))
    else $error("item queue overflow");

  a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_cutoff |-> out_force_x == 0 && out_force_y == 0 &&
    out_force_z == 0 && out_density_rate == 0 && out_energy_rate == 0)
    else $error("nonzero result for pair outside cutoff");
`endif

endmodule

### rtl/stpf_front.sv
module stpf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            in_del_x,
  input  logic signed [31:0]            in_del_y,
  input  logic signed [31:0]            in_del_z,
  input  logic signed [31:0]            in_dvel_x,
  input  logic signed [31:0]            in_dvel_y,
  input  logic signed [31:0]            in_dvel_z,
  input  logic [31:0]                   in_density_i,
  input  logic [31:0]                   in_density_j,
  input  logic [31:0]                   smoothing_length,
  input  logic [stpf_pkg::QCNT_W-1:0]   q_count,
  output logic                          push,
  output stpf_pkg::pair_t               push_item
);

  logic               s1_v_r;
  stpf_pkg::pair_t    s1_r;
  logic [63:0]        sq0_r, sq1_r, sq2_r, hsq_r;
  logic signed [63:0] sq0, sq1, sq2;
  logic [63:0]        hsq, rsq;
  logic               accept;

  assign busy   = ((stpf_pkg::QCNT_W+1)'(q_count) + (stpf_pkg::QCNT_W+1)'(s1_v_r))
                  >= (stpf_pkg::QCNT_W+1)'(stpf_pkg::QDEPTH);
  assign accept = start && !busy;

  assign sq0 = in_del_x * in_del_x;
  assign sq1 = in_del_y * in_del_y;
  assign sq2 = in_del_z * in_del_z;
  assign hsq = smoothing_length * smoothing_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    if (accept) begin
      s1_r.cut  <= 1'b0;
      s1_r.rsq  <= '0;
      s1_r.dx   <= in_del_x;
      s1_r.dy   <= in_del_y;
      s1_r.dz   <= in_del_z;
      s1_r.vx   <= in_dvel_x;
      s1_r.vy   <= in_dvel_y;
      s1_r.vz   <= in_dvel_z;
      s1_r.rhoi <= in_density_i;
      s1_r.rhoj <= in_density_j;
      sq0_r     <= sq0;
      sq1_r     <= sq1;
      sq2_r     <= sq2;
      hsq_r     <= hsq;
    end
  end

  assign rsq = sq0_r + sq1_r + sq2_r;

  always_comb begin
    push_item     = s1_r;
    push_item.rsq = rsq;
    push_item.cut = rsq < hsq_r;
  end

  assign push = s1_v_r;

endmodule

### rtl/stpf_queue.sv
module stpf_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  stpf_pkg::pair_t               push_item,
  input  logic                          pop,
  output stpf_pkg::pair_t               head,
  output logic                          empty,
  output logic [stpf_pkg::QCNT_W-1:0]   count
);

  stpf_pkg::pair_t                  mem [stpf_pkg::QDEPTH];
  logic [stpf_pkg::QPTR_W-1:0]      wr_r, rd_r;
  logic [stpf_pkg::QCNT_W-1:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  assign head  = mem[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

### rtl/stpf_back.sv
module stpf_back #(
  parameter int FRAC_BITS = stpf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stpf_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  stpf_pkg::pair_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  output logic signed [63:0] out_force_x,
  output logic signed [63:0] out_force_y,
  output logic signed [63:0] out_force_z,
  output logic signed [63:0] out_density_rate,
  output logic signed [63:0] out_energy_rate,
  output logic               out_in_cutoff
);

  localparam int SH  = 32 - FRAC_BITS;
  localparam int RSH = 64 - 2 * FRAC_BITS;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] msgn(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    c = (m > 64'(stpf_pkg::QMAX)) ? 64'(stpf_pkg::QMAX) : m;
    return neg ? -signed'(c) : signed'(c);
  endfunction

  stpf_pkg::st_t   st_r, st_nxt;
  logic [stpf_pkg::PC_W-1:0] pc_r;
  stpf_pkg::pair_t item_r;
  stpf_pkg::uop_t  u;

  logic signed [63:0] tmp [stpf_pkg::NTMP];

  stpf_pkg::op_t   op_r;
  stpf_pkg::cap_t  cap_r;
  logic [stpf_pkg::TMP_W-1:0] dst_r;
  logic signed [63:0] a_r, b_r, res_r;
  logic [63:0]        ua_r, ub_r;
  logic               neg_r, dzb_r, dsat_r;
  logic [5:0]         cnt_r;
  logic [127:0]       acc_r;
  logic [63:0]        rem_r;
  logic [62:0]        dd_r, q_r;
  logic [65:0]        srem_r;
  logic [63:0]        root_r;
  logic [127:0]       rad_r;

  logic signed [63:0] cfx_r, cfy_r, cfz_r, cdrho_r, cde_r;

  logic signed [63:0] opa, srcb, opb;
  logic [63:0]        ua_f, ub_f;
  logic               skip;

  logic [31:0]        ma, mb;
  logic [63:0]        pp;
  logic [127:0]       acc_n;
  logic [64:0]        r2;
  logic               dge;
  logic [63:0]        rem_n;
  logic [62:0]        q_n;
  logic [67:0]        rem2, trial;
  logic               sge;
  logic [65:0]        srem_n;
  logic [63:0]        root_n;
  logic signed [64:0] sum65;
  logic               ex_done;
  logic signed [63:0] ex_res;

  function automatic logic signed [63:0] src(input logic [4:0] s,
                                             input stpf_pkg::pair_t it,
                                             input stpf_pkg::cfg_t c,
                                             input logic signed [63:0] tv);
    logic signed [63:0] v;
    case (s)
      stpf_pkg::SRC_DX:   v = 64'(it.dx) <<< SH;
      stpf_pkg::SRC_DY:   v = 64'(it.dy) <<< SH;
      stpf_pkg::SRC_DZ:   v = 64'(it.dz) <<< SH;
      stpf_pkg::SRC_VX:   v = 64'(it.vx) <<< SH;
      stpf_pkg::SRC_VY:   v = 64'(it.vy) <<< SH;
      stpf_pkg::SRC_VZ:   v = 64'(it.vz) <<< SH;
      stpf_pkg::SRC_RHOI: v = signed'({32'd0, it.rhoi} << SH);
      stpf_pkg::SRC_RHOJ: v = signed'({32'd0, it.rhoj} << SH);
      stpf_pkg::SRC_H:    v = signed'({32'd0, c.smoothing_length} << SH);
      stpf_pkg::SRC_M:    v = signed'({32'd0, c.particle_mass} << SH);
      stpf_pkg::SRC_RHO0: v = signed'({32'd0, c.rest_density} << SH);
      stpf_pkg::SRC_B:    v = signed'({32'd0, c.tait_b} << SH);
      stpf_pkg::SRC_MU:   v = signed'({32'd0, c.dyn_viscosity} << SH);
      stpf_pkg::SRC_QONE: v = stpf_pkg::QONE;
      stpf_pkg::SRC_LUCY: v = c.dimension_3d ? stpf_pkg::LUCY_3D : stpf_pkg::LUCY_2D;
      stpf_pkg::SRC_ZERO: v = '0;
      default:            v = tv;
    endcase
    return v;
  endfunction

  assign u = stpf_pkg::uc_rom(pc_r);

  always_comb begin
    opa  = src(u.sa, item_r, cfg, tmp[u.sa[stpf_pkg::TMP_W-1:0]]);
    srcb = src(u.sb, item_r, cfg, tmp[u.sb[stpf_pkg::TMP_W-1:0]]);
    opb  = u.negb ? -srcb : srcb;
    ua_f = mag(opa);
    ub_f = mag(opb);
    skip = u.only3d && !cfg.dimension_3d;
  end

  // execution units
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin ma = ua_r[31:0];  mb = ub_r[31:0];  end
      2'd1:    begin ma = ua_r[31:0];  mb = ub_r[63:32]; end
      2'd2:    begin ma = ua_r[63:32]; mb = ub_r[31:0];  end
      default: begin ma = ua_r[63:32]; mb = ub_r[63:32]; end
    endcase
    pp = ma * mb;
    case (cnt_r[1:0])
      2'd0:    acc_n = acc_r + 128'(pp);
      2'd3:    acc_n = acc_r + (128'(pp) << 64);
      default: acc_n = acc_r + (128'(pp) << 32);
    endcase

    r2    = {rem_r, dd_r[62]};
    dge   = r2 >= {1'b0, ub_r};
    rem_n = dge ? 64'(r2 - {1'b0, ub_r}) : r2[63:0];
    q_n   = {q_r[61:0], dge};

    rem2   = {srem_r, rad_r[127:126]};
    trial  = {2'b00, root_r, 2'b01};
    sge    = rem2 >= trial;
    srem_n = sge ? 66'(rem2 - trial) : rem2[65:0];
    root_n = {root_r[62:0], sge};

    sum65 = 65'(a_r) + 65'(b_r);

    ex_done = 1'b1;
    ex_res  = '0;
    case (op_r)
      stpf_pkg::OP_ADD: begin
        if (sum65 > 65'(stpf_pkg::QMAX)) begin
          ex_res = stpf_pkg::QMAX;
        end else if (sum65 < -65'(stpf_pkg::QMAX)) begin
          ex_res = -stpf_pkg::QMAX;
        end else begin
          ex_res = sum65[63:0];
        end
      end
      stpf_pkg::OP_HALF: ex_res = -(a_r / 2);
      stpf_pkg::OP_MUL: begin
        ex_done = (cnt_r == 6'd3);
        ex_res  = (acc_n[127:95] != '0) ? msgn(neg_r, 64'(stpf_pkg::QMAX))
                                        : msgn(neg_r, {1'b0, acc_n[94:32]});
      end
      stpf_pkg::OP_DIV: begin
        if (dzb_r) begin
          ex_res = (a_r == '0) ? '0 : msgn(a_r[63], 64'(stpf_pkg::QMAX));
        end else if (dsat_r) begin
          ex_res = msgn(neg_r, 64'(stpf_pkg::QMAX));
        end else begin
          ex_done = (cnt_r == 6'd62);
          ex_res  = msgn(neg_r, {1'b0, q_n});
        end
      end
      stpf_pkg::OP_SQRT: begin
        ex_done = (cnt_r == 6'd63);
        ex_res  = signed'(root_n);
      end
      default: ex_res = '0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      stpf_pkg::ST_IDLE: begin
        if (!q_empty) begin
          st_nxt = q_head.cut ? stpf_pkg::ST_FETCH : stpf_pkg::ST_EMIT;
        end
      end
      stpf_pkg::ST_FETCH: begin
        if (u.op == stpf_pkg::OP_END) begin
          st_nxt = stpf_pkg::ST_EMIT;
        end else if (!skip) begin
          st_nxt = stpf_pkg::ST_EXEC;
        end
      end
      stpf_pkg::ST_EXEC: begin
        if (ex_done) begin
          st_nxt = stpf_pkg::ST_WB;
        end
      end
      stpf_pkg::ST_WB:   st_nxt = stpf_pkg::ST_FETCH;
      stpf_pkg::ST_EMIT: st_nxt = stpf_pkg::ST_IDLE;
      default:           st_nxt = stpf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (st_r == stpf_pkg::ST_IDLE) && !q_empty;
    out_valid = (st_r == stpf_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= stpf_pkg::ST_IDLE;
      pc_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop) begin
        pc_r <= '0;
      end else if ((st_r == stpf_pkg::ST_FETCH && skip && u.op != stpf_pkg::OP_END) ||
                   st_r == stpf_pkg::ST_WB) begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
      if (!q_head.cut) begin
        cfx_r   <= '0;
        cfy_r   <= '0;
        cfz_r   <= '0;
        cdrho_r <= '0;
        cde_r   <= '0;
      end
    end

    if (st_r == stpf_pkg::ST_FETCH) begin
      op_r   <= u.op;
      dst_r  <= u.dst;
      cap_r  <= u.cap;
      a_r    <= opa;
      b_r    <= opb;
      ua_r   <= ua_f;
      ub_r   <= ub_f;
      neg_r  <= opa[63] ^ opb[63];
      dzb_r  <= (ub_f == '0);
      dsat_r <= {31'd0, ua_f} >= {ub_f, 31'd0};
      cnt_r  <= '0;
      acc_r  <= '0;
      rem_r  <= {31'd0, ua_f[63:31]};
      dd_r   <= {ua_f[30:0], 32'd0};
      q_r    <= '0;
      srem_r <= '0;
      root_r <= '0;
      rad_r  <= {64'd0, item_r.rsq} << RSH;
    end

    if (st_r == stpf_pkg::ST_EXEC) begin
      cnt_r  <= cnt_r + 1'b1;
      acc_r  <= acc_n;
      rem_r  <= rem_n;
      dd_r   <= {dd_r[61:0], 1'b0};
      q_r    <= q_n;
      srem_r <= srem_n;
      root_r <= root_n;
      rad_r  <= {rad_r[125:0], 2'b00};
      if (ex_done) begin
        res_r <= ex_res;
      end
    end

    if (st_r == stpf_pkg::ST_WB) begin
      tmp[dst_r] <= res_r;
      case (cap_r)
        stpf_pkg::CAP_FX:   cfx_r   <= res_r;
        stpf_pkg::CAP_FY:   cfy_r   <= res_r;
        stpf_pkg::CAP_FZ:   cfz_r   <= res_r;
        stpf_pkg::CAP_DRHO: cdrho_r <= res_r;
        stpf_pkg::CAP_DE:   cde_r   <= res_r;
        default: ;
      endcase
    end
  end

  assign out_force_x      = cfx_r;
  assign out_force_y      = cfy_r;
  assign out_force_z      = cfz_r;
  assign out_density_rate = cdrho_r;
  assign out_energy_rate  = cde_r;
  assign out_in_cutoff    = item_r.cut;

endmodule
